>>> rtl/csv_record_tokenizer_top_defines.svh
// Assertion macros for the CSV tokenizer checker.
// Both expect aclk and aresetn in the scope where they are used.
`ifndef CSV_RECORD_TOKENIZER_TOP_DEFINES_SVH
`define CSV_RECORD_TOKENIZER_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CSVTOK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CSVTOK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/csvtok_pkg.sv
package csvtok_pkg;

    localparam int MAX_LEADING_SPACES = 32;
    localparam int SPACE_CNT_W = $clog2(MAX_LEADING_SPACES + 1);
    localparam int SPACE_IDX_W = (MAX_LEADING_SPACES > 1) ? $clog2(MAX_LEADING_SPACES) : 1;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_END  = 1'b1;

    localparam logic [1:0] KIND_DATA      = 2'd0;
    localparam logic [1:0] KIND_FIELD_END = 2'd1;
    localparam logic [1:0] KIND_REC_END   = 2'd2;
    localparam logic [1:0] KIND_ERROR     = 2'd3;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_STRAY_QUOTE = 3'd1;
    localparam logic [2:0] ERR_AFTER_CLOSE = 3'd2;
    localparam logic [2:0] ERR_UNCLOSED    = 3'd3;
    localparam logic [2:0] ERR_WS_OVERFLOW = 3'd4;

    typedef struct packed {
        logic       req_type;
        logic [7:0] in_byte;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [2:0]  error_code;
        logic [31:0] record_count;
        logic        last_of_run;
    } res_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic load_direct;
        logic load_space;
        logic load_final;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic emit;        // request yields a result
        logic flush;       // buffered whitespace goes out first
        logic flush_last;  // flush index at last buffered entry
    } dp_status_t;

endpackage

>>> rtl/csvtok_datapath.sv
module csvtok_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  csvtok_pkg::req_t       s_data,
    input  csvtok_pkg::dp_cmd_t    cmd,
    output csvtok_pkg::dp_status_t status,
    output csvtok_pkg::res_t       m_data
);
    import csvtok_pkg::*;

    localparam logic [2:0] MODE_START  = 3'd0;
    localparam logic [2:0] MODE_UNQ    = 3'd1;
    localparam logic [2:0] MODE_INQ    = 3'd2;
    localparam logic [2:0] MODE_QSEEN  = 3'd3;
    localparam logic [2:0] MODE_CLOSED = 3'd4;
    localparam logic [2:0] MODE_SKIP   = 3'd5;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    logic [2:0]                    mode_reg, mode_next;
    logic                          qne_reg, qne_next;
    logic                          acr_reg, acr_next;
    logic                          ropen_reg, ropen_next;
    logic [SPACE_CNT_W-1:0]        pcount_reg, pcount_next;
    logic [31:0]                   records_reg, records_next;
    logic [SPACE_IDX_W-1:0]        flush_idx_reg;
    logic [MAX_LEADING_SPACES-1:0] kinds_reg;
    res_t                          final_reg;
    res_t                          out_reg;

    logic       emit;
    logic       kind_wr;
    logic [1:0] res_kind;
    logic [7:0] res_byte;
    logic [2:0] res_err;
    logic       dec_flush;
    res_t       dec_res;
    res_t       space_res;

    always_comb begin
        logic [7:0] b;
        logic       is_ws;
        logic       is_brk;
        logic [2:0] eff;
        logic       do_fail;
        logic [2:0] fail_code;

        b         = s_data.in_byte;
        is_ws     = (b == CH_SPACE) || (b == CH_TAB);
        is_brk    = (b == CH_CR) || (b == CH_LF);
        eff       = mode_reg;
        do_fail   = 1'b0;
        fail_code = ERR_NONE;

        mode_next    = mode_reg;
        qne_next     = qne_reg;
        acr_next     = acr_reg;
        ropen_next   = ropen_reg;
        pcount_next  = pcount_reg;
        records_next = records_reg;
        kind_wr      = 1'b0;
        emit         = 1'b0;
        res_kind     = KIND_DATA;
        res_byte     = 8'd0;
        res_err      = ERR_NONE;

        if (s_data.req_type == REQ_END) begin
            acr_next = 1'b0;
            if (mode_reg == MODE_SKIP) begin
                mode_next   = MODE_START;
                pcount_next = '0;
                qne_next    = 1'b0;
                ropen_next  = 1'b0;
            end else if (mode_reg == MODE_INQ) begin
                do_fail   = 1'b1;
                fail_code = ERR_UNCLOSED;
                eff       = MODE_START;
            end else if (!ropen_reg) begin
                mode_next   = MODE_START;
                pcount_next = '0;
                qne_next    = 1'b0;
            end else begin
                mode_next    = MODE_START;
                pcount_next  = '0;
                qne_next     = 1'b0;
                records_next = records_reg + 32'd1;
                ropen_next   = 1'b0;
                emit         = 1'b1;
                res_kind     = KIND_REC_END;
            end
        end else begin
            acr_next = 1'b0;
            if (acr_reg && (b == CH_LF)) begin
                // LF of a CRLF pair: already counted
            end else if (mode_reg == MODE_SKIP) begin
                if (is_brk) begin
                    records_next = records_reg + 32'd1;
                    acr_next     = (b == CH_CR);
                    mode_next    = MODE_START;
                    ropen_next   = 1'b0;
                end
            end else begin
                ropen_next = 1'b1;
                if (mode_reg == MODE_INQ) begin
                    if (b == CH_QUOTE) begin
                        mode_next = MODE_QSEEN;
                    end else begin
                        qne_next = 1'b1;
                        emit     = 1'b1;
                        res_byte = b;
                    end
                end else if ((mode_reg == MODE_QSEEN) && (b == CH_QUOTE)) begin
                    qne_next  = 1'b1;
                    mode_next = MODE_INQ;
                    emit      = 1'b1;
                    res_byte  = b;
                end else begin
                    eff       = (mode_reg == MODE_QSEEN) ? MODE_CLOSED : mode_reg;
                    mode_next = eff;
                    if (b == CH_COMMA) begin
                        pcount_next = '0;
                        qne_next    = 1'b0;
                        mode_next   = MODE_START;
                        emit        = 1'b1;
                        res_kind    = KIND_FIELD_END;
                    end else if (is_brk) begin
                        pcount_next  = '0;
                        qne_next     = 1'b0;
                        mode_next    = MODE_START;
                        records_next = records_reg + 32'd1;
                        ropen_next   = 1'b0;
                        acr_next     = (b == CH_CR);
                        emit         = 1'b1;
                        res_kind     = KIND_REC_END;
                    end else if (eff == MODE_CLOSED) begin
                        if (is_ws) begin
                            // trailing whitespace dropped
                        end else if (b == CH_QUOTE) begin
                            if (qne_reg) begin
                                do_fail   = 1'b1;
                                fail_code = ERR_STRAY_QUOTE;
                            end else begin
                                // "" followed by a quote reopens the field
                                mode_next = MODE_INQ;
                            end
                        end else begin
                            do_fail   = 1'b1;
                            fail_code = ERR_AFTER_CLOSE;
                        end
                    end else if (eff == MODE_UNQ) begin
                        if (b == CH_QUOTE) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_STRAY_QUOTE;
                        end else begin
                            emit     = 1'b1;
                            res_byte = b;
                        end
                    end else begin
                        mode_next = MODE_START;
                        if (is_ws) begin
                            if (pcount_reg >= SPACE_CNT_W'(MAX_LEADING_SPACES)) begin
                                do_fail   = 1'b1;
                                fail_code = ERR_WS_OVERFLOW;
                            end else begin
                                kind_wr     = 1'b1;
                                pcount_next = pcount_reg + SPACE_CNT_W'(1);
                            end
                        end else if (b == CH_QUOTE) begin
                            pcount_next = '0;
                            qne_next    = 1'b0;
                            mode_next   = MODE_INQ;
                        end else begin
                            pcount_next = '0;
                            mode_next   = MODE_UNQ;
                            emit        = 1'b1;
                            res_byte    = b;
                        end
                    end
                end
            end
        end

        if (do_fail) begin
            pcount_next = '0;
            qne_next    = 1'b0;
            ropen_next  = 1'b0;
            mode_next   = (s_data.req_type == REQ_END) ? MODE_START : MODE_SKIP;
            emit        = 1'b1;
            res_kind    = KIND_ERROR;
            res_err     = fail_code;
        end
    end

    // buffered whitespace is only ever non-empty at field start
    assign dec_flush = emit && (res_kind != KIND_ERROR) && (pcount_reg != '0);

    always_comb begin
        dec_res.kind         = res_kind;
        dec_res.out_byte     = res_byte;
        dec_res.error_code   = res_err;
        dec_res.record_count = records_next;
        dec_res.last_of_run  = 1'b1;

        space_res.kind         = KIND_DATA;
        space_res.out_byte     = kinds_reg[flush_idx_reg] ? CH_TAB : CH_SPACE;
        space_res.error_code   = ERR_NONE;
        space_res.record_count = records_reg;
        space_res.last_of_run  = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_START;
            qne_reg       <= 1'b0;
            acr_reg       <= 1'b0;
            ropen_reg     <= 1'b0;
            pcount_reg    <= '0;
            records_reg   <= '0;
            flush_idx_reg <= '0;
        end else begin
            if (cmd.accept) begin
                mode_reg      <= mode_next;
                qne_reg       <= qne_next;
                acr_reg       <= acr_next;
                ropen_reg     <= ropen_next;
                flush_idx_reg <= '0;
                // on a flush, count and buffer stay until the closing result leaves
                if (!dec_flush) begin
                    pcount_reg  <= pcount_next;
                    records_reg <= records_next;
                end
            end
            if (cmd.load_space) begin
                flush_idx_reg <= flush_idx_reg + SPACE_IDX_W'(1);
            end
            if (cmd.load_final) begin
                pcount_reg  <= '0;
                records_reg <= final_reg.record_count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && kind_wr) begin
            kinds_reg[pcount_reg[SPACE_IDX_W-1:0]] <= (s_data.in_byte == CH_TAB);
        end
        if (cmd.accept) begin
            final_reg <= dec_res;
        end
        if (cmd.load_direct) begin
            out_reg <= dec_res;
        end else if (cmd.load_space) begin
            out_reg <= space_res;
        end else if (cmd.load_final) begin
            out_reg <= final_reg;
        end
    end

    assign status.emit       = emit;
    assign status.flush      = dec_flush;
    assign status.flush_last =
        ((SPACE_CNT_W'(flush_idx_reg) + SPACE_CNT_W'(1)) == pcount_reg);
    assign m_data = out_reg;

endmodule

>>> rtl/csvtok_ctrl.sv
module csvtok_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  csvtok_pkg::dp_status_t status,
    output csvtok_pkg::dp_cmd_t    cmd
);
    import csvtok_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FLUSH = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;
    logic       accept;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    always_comb begin
        cmd.accept      = accept;
        cmd.load_direct = accept && status.emit && !status.flush;
        cmd.load_space  = (state_reg == ST_FLUSH) && out_free;
        cmd.load_final  = (state_reg == ST_FINAL) && out_free;

        m_valid_next = (m_valid_reg && !m_ready) || cmd.load_direct ||
                       cmd.load_space || cmd.load_final;

        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && status.flush) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (out_free && status.flush_last) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

>>> rtl/csv_record_tokenizer_top.sv
// CSV record tokenizer.
// Input channel (s_valid/s_ready/s_data): one request per text byte, or an
// end-of-input request. Output channel (m_valid/m_ready/m_data): content
// bytes, field-end and record-end marks and error reports, in order; the
// last result caused by a request carries last_of_run.
// A result that no flush holds back is valid in the cycle after its request
// is accepted. Requests with no result are absorbed without a stall.
// Throughput: one request per cycle while the receiver keeps up. With N
// buffered spaces/tabs ahead of a field, its first result is held back;
// the N blanks from the whitespace buffer, then the closing result, leave
// one per cycle while the receiver keeps up; no request is taken meanwhile.
// The output register parts the two sides: a new request is taken in the
// same cycle the waiting result leaves. While m_ready is low, the result
// holds and s_ready drops once the register is full.
// Reset (aresetn low, synchronous): parser returns to field start, record
// count cleared, output register emptied. No clearing pass is needed.
module csv_record_tokenizer_top (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  csvtok_pkg::req_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output csvtok_pkg::res_t m_data
);
    import csvtok_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    csvtok_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    csvtok_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_data  (m_data)
    );

endmodule

>>> rtl/csvtok_checker.sv
`include "csv_record_tokenizer_top_defines.svh"

module csvtok_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input csvtok_pkg::res_t m_data
);
    import csvtok_pkg::*;

    `CSVTOK_ASSERT_NEXT(a_out_hold,
        m_valid && !m_ready,
        m_valid && $stable(m_data),
        "result dropped or changed while stalled")

    // mid-burst results come only from a whitespace flush, which blocks new requests
    `CSVTOK_ASSERT_NOW(a_burst_blocks_input,
        m_valid && !m_data.last_of_run,
        !s_ready,
        "request taken during a flush burst")

    `CSVTOK_ASSERT_NOW(a_error_fields,
        m_valid && (m_data.kind == KIND_ERROR),
        (m_data.out_byte == 8'd0) && (m_data.error_code != ERR_NONE) && m_data.last_of_run,
        "malformed error report")

    `CSVTOK_ASSERT_NOW(a_mark_fields,
        m_valid && ((m_data.kind == KIND_FIELD_END) || (m_data.kind == KIND_REC_END)),
        (m_data.out_byte == 8'd0) && (m_data.error_code == ERR_NONE) && m_data.last_of_run,
        "malformed field mark")

endmodule

bind csv_record_tokenizer_top csvtok_checker u_checker (.*);
